// ===== rtl/ftdc_pkg.sv =====
// ----------------------------------------------------------------------------
// ftdc_pkg
// Shared types, codes and reset values of the thermostat / defrost controller.
// ----------------------------------------------------------------------------
package ftdc_pkg;

	localparam int TIME_WIDTH_DEF = 32;
	localparam int TEMP_W         = 12;
	localparam int BAND_W         = 9;
	localparam int SECS_W         = 32;
	localparam int RETRY_W        = 8;
	localparam int CFG_DATA_W     = 32;
	localparam int CFG_IDX_W      = 3;

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_COOL    = 2'd1,
		MODE_DEFROST = 2'd2,
		MODE_FAULT   = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SETPOINT     = 3'd0,
		REG_BAND         = 3'd1,
		REG_WARM_LIMIT   = 3'd2,
		REG_COLD_LIMIT   = 3'd3,
		REG_CONFIRM_SECS = 3'd4,
		REG_PERIOD_SECS  = 3'd5,
		REG_LENGTH_SECS  = 3'd6,
		REG_RETRY_LIMIT  = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] setpoint;
		logic [BAND_W-1:0]        band_half_width;
		logic signed [TEMP_W-1:0] warm_alarm_limit;
		logic signed [TEMP_W-1:0] cold_alarm_limit;
		logic [SECS_W-1:0]        alarm_confirm_seconds;
		logic [SECS_W-1:0]        defrost_period_seconds;
		logic [SECS_W-1:0]        defrost_length_seconds;
		logic [RETRY_W-1:0]       fault_retry_limit;
	} cfg_t;

	// controller state other than the time stamps
	typedef struct packed {
		mode_t                    mode;
		logic                     comp;
		logic [RETRY_W-1:0]       fault_run;
		logic                     armed;
		logic signed [TEMP_W-1:0] held;
		logic                     warm;
		logic                     cold;
		logic                     sensor;
	} flags_t;

	localparam logic signed [TEMP_W-1:0] SETPOINT_RST   = 12'sd64;
	localparam logic [BAND_W-1:0]        BAND_RST       = 9'd16;
	localparam logic signed [TEMP_W-1:0] WARM_LIMIT_RST = 12'sd160;
	localparam logic signed [TEMP_W-1:0] COLD_LIMIT_RST = 12'sd0;
	localparam logic [SECS_W-1:0]        CONFIRM_RST    = 32'd600;
	localparam logic [SECS_W-1:0]        PERIOD_RST     = 32'd28800;
	localparam logic [SECS_W-1:0]        LENGTH_RST     = 32'd1800;
	localparam logic [RETRY_W-1:0]       RETRY_RST      = 8'd3;

endpackage

// ===== rtl/ftdc_ifs.sv =====
// ----------------------------------------------------------------------------
// ftdc_in_if / ftdc_out_if
// Valid/ready channels carrying a sensor tick in and a status word out.
// ----------------------------------------------------------------------------
interface ftdc_in_if import ftdc_pkg::*; #(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
);
	logic                     valid;
	logic                     ready;
	logic [TIME_WIDTH-1:0]    now_seconds;
	logic                     reading_valid;
	logic signed [TEMP_W-1:0] sample_temperature;

	modport source (output valid, now_seconds, reading_valid, sample_temperature,
		input ready);
	modport sink (input valid, now_seconds, reading_valid, sample_temperature,
		output ready);
endinterface

interface ftdc_out_if import ftdc_pkg::*;;
	logic                     valid;
	logic                     ready;
	mode_t                    operating_mode;
	logic                     compressor_request;
	logic                     alarm_too_warm;
	logic                     alarm_too_cold;
	logic                     sensor_alarm;
	logic                     defrost_begun;
	logic signed [TEMP_W-1:0] reported_temperature;

	modport source (output valid, operating_mode, compressor_request, alarm_too_warm,
		alarm_too_cold, sensor_alarm, defrost_begun, reported_temperature,
		input ready);
	modport sink (input valid, operating_mode, compressor_request, alarm_too_warm,
		alarm_too_cold, sensor_alarm, defrost_begun, reported_temperature,
		output ready);
endinterface

// ===== rtl/ftdc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ftdc_cfg_regs
// Configuration register bank, written by index, reset to the default values.
// ----------------------------------------------------------------------------
module ftdc_cfg_regs import ftdc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setpoint               <= SETPOINT_RST;
			cfg_q.band_half_width        <= BAND_RST;
			cfg_q.warm_alarm_limit       <= WARM_LIMIT_RST;
			cfg_q.cold_alarm_limit       <= COLD_LIMIT_RST;
			cfg_q.alarm_confirm_seconds  <= CONFIRM_RST;
			cfg_q.defrost_period_seconds <= PERIOD_RST;
			cfg_q.defrost_length_seconds <= LENGTH_RST;
			cfg_q.fault_retry_limit      <= RETRY_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_SETPOINT:     cfg_q.setpoint <= $signed(cfg_wdata[TEMP_W-1:0]);
				REG_BAND:         cfg_q.band_half_width <= cfg_wdata[BAND_W-1:0];
				REG_WARM_LIMIT:   cfg_q.warm_alarm_limit <= $signed(cfg_wdata[TEMP_W-1:0]);
				REG_COLD_LIMIT:   cfg_q.cold_alarm_limit <= $signed(cfg_wdata[TEMP_W-1:0]);
				REG_CONFIRM_SECS: cfg_q.alarm_confirm_seconds <= cfg_wdata[SECS_W-1:0];
				REG_PERIOD_SECS:  cfg_q.defrost_period_seconds <= cfg_wdata[SECS_W-1:0];
				REG_LENGTH_SECS:  cfg_q.defrost_length_seconds <= cfg_wdata[SECS_W-1:0];
				REG_RETRY_LIMIT:  cfg_q.fault_retry_limit <= cfg_wdata[RETRY_W-1:0];
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/ftdc_tick_logic.sv =====
// ----------------------------------------------------------------------------
// ftdc_tick_logic
// Next-state logic for one tick: sensor check, defrost timer, hysteresis
// cooling and temperature alarms.
// ----------------------------------------------------------------------------
module ftdc_tick_logic import ftdc_pkg::*; #(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  cfg_t                     cfg,
	input  flags_t                   cur,
	input  logic [TIME_WIDTH-1:0]    last_end,
	input  logic [TIME_WIDTH-1:0]    dbegin,
	input  logic [TIME_WIDTH-1:0]    arm_time,
	input  logic [TIME_WIDTH-1:0]    now,
	input  logic                     reading_valid,
	input  logic signed [TEMP_W-1:0] temp,
	output flags_t                   nxt,
	output logic [TIME_WIDTH-1:0]    last_end_nxt,
	output logic [TIME_WIDTH-1:0]    dbegin_nxt,
	output logic [TIME_WIDTH-1:0]    arm_time_nxt,
	output logic                     begun
);

	localparam int CMP_W = (TIME_WIDTH > SECS_W) ? TIME_WIDTH : SECS_W;
	localparam int THR_W = TEMP_W + 2;

	logic [TIME_WIDTH-1:0]    d_len, d_per, d_arm;
	logic                     len_done, per_done, confirm_done;
	logic signed [TEMP_W-1:0] t;
	logic signed [THR_W-1:0]  t_x, sp_x, bw_x, up_th, dn_th;
	logic                     hot, cold;

	// differences wrap modulo 2^TIME_WIDTH
	assign d_len = now - dbegin;
	assign d_per = now - last_end;
	assign d_arm = now - arm_time;
	assign len_done     = CMP_W'(d_len) >= CMP_W'(cfg.defrost_length_seconds);
	assign per_done     = CMP_W'(d_per) >= CMP_W'(cfg.defrost_period_seconds);
	assign confirm_done = CMP_W'(d_arm) >= CMP_W'(cfg.alarm_confirm_seconds);

	assign t     = reading_valid ? temp : cur.held;
	assign t_x   = THR_W'(t);
	assign sp_x  = THR_W'(cfg.setpoint);
	assign bw_x  = $signed({{(THR_W-BAND_W){1'b0}}, cfg.band_half_width});
	assign up_th = sp_x + bw_x;
	assign dn_th = sp_x - bw_x;
	assign hot   = t > cfg.warm_alarm_limit;
	assign cold  = t < cfg.cold_alarm_limit;

	always_comb begin
		nxt          = cur;
		last_end_nxt = last_end;
		dbegin_nxt   = dbegin;
		arm_time_nxt = arm_time;
		begun        = 1'b0;

		if (reading_valid) begin
			nxt.held      = temp;
			nxt.fault_run = '0;
			if (cur.mode == MODE_FAULT) begin
				nxt.sensor = 1'b0;
				nxt.mode   = MODE_IDLE;
			end
		end else begin
			if (cur.fault_run != '1)
				nxt.fault_run = cur.fault_run + 1'b1;
			if (nxt.fault_run >= cfg.fault_retry_limit) begin
				nxt.sensor = 1'b1;
				nxt.comp   = 1'b0;
				nxt.mode   = MODE_FAULT;
			end
		end

		if (nxt.mode != MODE_FAULT) begin
			if (nxt.mode == MODE_DEFROST) begin
				if (len_done) begin
					nxt.comp     = 1'b0;
					last_end_nxt = now;
					nxt.mode     = MODE_IDLE;
				end
			end else if (per_done) begin
				nxt.comp   = 1'b0;
				dbegin_nxt = now;
				begun      = 1'b1;
				nxt.mode   = MODE_DEFROST;
			end

			// cooling also runs on the tick a defrost ends
			if (nxt.mode == MODE_IDLE && t_x >= up_th) begin
				nxt.comp = 1'b1;
				nxt.mode = MODE_COOL;
			end else if (nxt.mode == MODE_COOL && t_x <= dn_th) begin
				nxt.comp = 1'b0;
				nxt.mode = MODE_IDLE;
			end

			if (hot || cold) begin
				if (!cur.armed) begin
					nxt.armed    = 1'b1;
					arm_time_nxt = now;
				end else if (confirm_done) begin
					if (hot)
						nxt.warm = 1'b1;
					if (cold)
						nxt.cold = 1'b1;
				end
			end else begin
				nxt.armed = 1'b0;
				nxt.warm  = 1'b0;
				nxt.cold  = 1'b0;
			end
		end
	end

endmodule

// ===== rtl/fridge_thermostat_defrost_controller.sv =====
// ----------------------------------------------------------------------------
// fridge_thermostat_defrost_controller
// Thermostat with hysteresis cooling, timed defrost, sensor fault handling
// and latched temperature alarms.
// ----------------------------------------------------------------------------
// Usage:
//   tick   : one word per sensor poll (time in seconds, read-ok flag,
//            temperature in 1/16 degC). Accepted on valid && ready.
//   result : one status word per tick, in tick order (mode, compressor
//            level, alarms, defrost-start pulse, last good temperature).
//   cfg_*  : register writes by index; write only while no tick is in flight.
// The accepting edge loads the tick into the input register; the tick logic
// then runs from that register into the result register, where the result
// word becomes valid. A new tick is taken every cycle while result is not
// stalled; the whole update is a single pass between those two registers,
// and the controller state is written back on the edge that loads the result.
// When result is stalled the word waits in the result register and one more
// tick is held in the input register; tick.ready then drops until the
// result is taken.
// Reset: configuration and controller state return to their defaults, mode
// idle, compressor off, alarms clear, alarm timer disarmed, no word pending.
// ----------------------------------------------------------------------------
module fridge_thermostat_defrost_controller import ftdc_pkg::*; #(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	ftdc_in_if.sink               tick,
	ftdc_out_if.source            result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t cfg;

	// input stage
	logic                     vld_s1;
	logic [TIME_WIDTH-1:0]    now_s1;
	logic                     rvalid_s1;
	logic signed [TEMP_W-1:0] temp_s1;

	// controller state
	flags_t                flags_q;
	logic [TIME_WIDTH-1:0] last_end_q, dbegin_q, arm_time_q;

	// tick logic outputs
	flags_t                flags_nxt;
	logic [TIME_WIDTH-1:0] last_end_nxt, dbegin_nxt, arm_time_nxt;
	logic                  begun;

	// result register
	logic                     out_vld_q;
	mode_t                    mode_q;
	logic                     comp_q, warm_q, cold_q, sensor_q, begun_q;
	logic signed [TEMP_W-1:0] temp_q;

	logic fire;

	ftdc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	ftdc_tick_logic #(.TIME_WIDTH(TIME_WIDTH)) u_tick (
		.cfg           (cfg),
		.cur           (flags_q),
		.last_end      (last_end_q),
		.dbegin        (dbegin_q),
		.arm_time      (arm_time_q),
		.now           (now_s1),
		.reading_valid (rvalid_s1),
		.temp          (temp_s1),
		.nxt           (flags_nxt),
		.last_end_nxt  (last_end_nxt),
		.dbegin_nxt    (dbegin_nxt),
		.arm_time_nxt  (arm_time_nxt),
		.begun         (begun)
	);

	assign fire       = vld_s1 && (!out_vld_q || result.ready);
	assign tick.ready = !vld_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (tick.ready) begin
			vld_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			now_s1    <= TIME_WIDTH'(tick.now_seconds);
			rvalid_s1 <= tick.reading_valid;
			temp_s1   <= tick.sample_temperature;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q.mode      <= MODE_IDLE;
			flags_q.comp      <= 1'b0;
			flags_q.fault_run <= '0;
			flags_q.armed     <= 1'b0;
			flags_q.held      <= '0;
			flags_q.warm      <= 1'b0;
			flags_q.cold      <= 1'b0;
			flags_q.sensor    <= 1'b0;
			last_end_q        <= '0;
			dbegin_q          <= '0;
			arm_time_q        <= '0;
		end else if (fire) begin
			flags_q    <= flags_nxt;
			last_end_q <= last_end_nxt;
			dbegin_q   <= dbegin_nxt;
			arm_time_q <= arm_time_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (fire) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			mode_q   <= flags_nxt.mode;
			comp_q   <= flags_nxt.comp;
			warm_q   <= flags_nxt.warm;
			cold_q   <= flags_nxt.cold;
			sensor_q <= flags_nxt.sensor;
			begun_q  <= begun;
			temp_q   <= flags_nxt.held;
		end
	end

	assign result.valid                = out_vld_q;
	assign result.operating_mode       = mode_q;
	assign result.compressor_request   = comp_q;
	assign result.alarm_too_warm       = warm_q;
	assign result.alarm_too_cold       = cold_q;
	assign result.sensor_alarm         = sensor_q;
	assign result.defrost_begun        = begun_q;
	assign result.reported_temperature = temp_q;

`ifndef SYNTHESIS
	// compressor runs exactly in the cooling mode
	a_comp_mode: assert property (@(posedge clk) disable iff (!arst_n)
		flags_q.comp == (flags_q.mode == MODE_COOL))
		else $error("compressor level disagrees with mode");

	// sensor alarm is up exactly in the fault mode
	a_sensor_mode: assert property (@(posedge clk) disable iff (!arst_n)
		flags_q.sensor == (flags_q.mode == MODE_FAULT))
		else $error("sensor alarm disagrees with mode");

	// a defrost-start pulse always comes with the defrost mode
	a_begun_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && begun_q |-> mode_q == MODE_DEFROST)
		else $error("defrost pulse outside defrost mode");

	// a stalled input word is kept until the tick logic takes it
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !fire |=> vld_s1 && $stable(now_s1) && $stable(rvalid_s1)
			&& $stable(temp_s1))
		else $error("input stage lost a word");
`endif

endmodule
